// ===== rtl/fcnt_pkg.sv =====
// shared constants and the table entry layout for the flow counter table
// no dependencies
package fcnt_pkg;

   localparam int DEF_TABLE_ENTRIES = 16384;
   localparam int DEF_TABLE_WAYS    = 4;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [3:0] IP_V4     = 4'd4;

   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 264;

   // one way of a set: flow key and its four counters
   typedef struct packed {
      logic [63:0] cgroup;
      logic [63:0] addresses;
      logic [39:0] ports_protocol;
      logic [63:0] tx_bytes;
      logic [63:0] tx_pkts;
      logic [63:0] rx_bytes;
      logic [63:0] rx_pkts;
   } entry_type;

endpackage

// ===== rtl/flow_counter_table_core.sv =====
// flow counter table top level: key build, set hash, lookup, lru update
// depends on fcnt_pkg
//
// per-flow packet and byte accounting for ipv4 packets
// req channel: one item per packet (header fields in tdata, direction in tuser)
// rsp channel: one item per request with the flow's updated counters
// a packet with an unreadable header or a version other than 4 is dropped:
//   its result item is all zero and the table is left alone
// a kept packet is looked up in a set-associative table; a hit bumps the
//   counters of its direction, a miss fills the lowest free way or replaces
//   the least recently used one
// steps: a dropped packet goes straight to the output load; a kept packet
//   goes through the set-index remainder (three reciprocal folding steps,
//   each a quotient estimate and then a subtraction), one memory read, a
//   compare, a write-back and the output load
// one item is in flight at a time, so no new request is taken until the
//   last one's result has been loaded into the output register
// reset: valid marks and lru ranks live in a memory that a clearing pass
//   sweeps set by set after reset; req_tready stays low until it ends
// stall: a result waits in the output register while rsp_tready is low;
//   the next request is taken once the block is idle again
module flow_counter_table_core
   import fcnt_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int TABLE_WAYS    = DEF_TABLE_WAYS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cgroup[63:0], header_ok[64], ip_version[68:65], protocol[76:69],
   // header_src_addr[108:77], header_dst_addr[140:109], ports_ok[141],
   // header_src_port[157:142], header_dst_port[173:158],
   // packet_length[189:174], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // egress flag
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // recorded[0], new_flow[1], evicted[2], tx byte count[66:3],
   // tx packet count[130:67], rx byte count[194:131],
   // rx packet count[258:195], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int SETS   = (TABLE_ENTRIES / TABLE_WAYS > 0) ? TABLE_ENTRIES / TABLE_WAYS : 1;
   localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WW     = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
   localparam int RW     = WW;
   localparam int RL     = $clog2(SETS);
   // reciprocal of the set count scaled by 2^(32+RL), between 2^32 and 2^33
   localparam logic [32:0] RECIP = 33'((64'd1 << (32 + RL)) / 64'(SETS));
   localparam logic [16:0] DIV_C = 17'(SETS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_FOLD, S_READ, S_EVAL, S_WRITE, S_OUT
   } state_type;

   // per-set recency and valid marks
   typedef struct packed {
      logic [TABLE_WAYS-1:0]         valid;
      logic [TABLE_WAYS-1:0][RW-1:0] rank;
   } meta_type;

   typedef entry_type [TABLE_WAYS-1:0] row_type;

   // ---------------------------------------------------------------- memories
   row_type  ent_mem  [SETS];
   meta_type meta_mem [SETS];

   row_type  ent_rd_ff;
   meta_type meta_rd_ff;
   logic     ent_we, meta_we;
   row_type  ent_wd;
   meta_type meta_wd;
   logic [SW-1:0] meta_wa;

   state_type state_ff;
   logic [SW-1:0] set_ff;
   logic [SW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[set_ff] <= ent_wd;
      ent_rd_ff <= ent_mem[set_ff];
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
      meta_rd_ff <= meta_mem[set_ff];
   end

   // ---------------------------------------------------------------- key build
   logic        in_hok, in_pok, in_egr, in_drop, in_ports;
   logic [3:0]  in_ver;
   logic [7:0]  in_proto;
   logic [31:0] in_hs, in_hd, in_sa, in_da;
   logic [15:0] in_hsp, in_hdp, in_sp, in_dp, in_len;
   logic [63:0] in_cg, in_hash;

   always_comb begin
      in_cg    = req_tdata[63:0];
      in_hok   = req_tdata[64];
      in_ver   = req_tdata[68:65];
      in_proto = req_tdata[76:69];
      in_hs    = req_tdata[108:77];
      in_hd    = req_tdata[140:109];
      in_pok   = req_tdata[141];
      in_hsp   = req_tdata[157:142];
      in_hdp   = req_tdata[173:158];
      in_len   = req_tdata[189:174];
      in_egr   = req_tuser;
      in_drop  = !in_hok || (in_ver != IP_V4);
      // ports only for tcp and udp with readable port words
      in_ports = ((in_proto == PROTO_TCP) || (in_proto == PROTO_UDP)) && in_pok;
      // ingress swaps source and destination
      if (in_egr) begin
         in_sa = in_hs;
         in_da = in_hd;
         in_sp = in_ports ? in_hsp : 16'd0;
         in_dp = in_ports ? in_hdp : 16'd0;
      end else begin
         in_sa = in_hd;
         in_da = in_hs;
         in_sp = in_ports ? in_hdp : 16'd0;
         in_dp = in_ports ? in_hsp : 16'd0;
      end
      in_hash = in_cg ^ {32'd0, in_cg[63:32]} ^ {32'd0, in_sa} ^ {32'd0, in_da}
              ^ {32'd0, in_sp, in_dp} ^ {56'd0, in_proto};
   end

   // ---------------------------------------------------------------- key regs
   logic [63:0] key_cg_ff, key_addr_ff, len_ff;
   logic [39:0] key_pp_ff;
   logic        egr_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         key_cg_ff   <= in_cg;
         key_addr_ff <= {in_sa, in_da};
         key_pp_ff   <= {in_sp, in_dp, in_proto};
         egr_ff      <= in_egr;
         len_ff      <= {48'd0, in_len};
      end
   end

   // ---------------------------------------------------------------- lookup
   logic          ev_hit, ev_free, ev_found;
   logic [WW-1:0] ev_hit_way, ev_free_way, ev_lru_way;
   logic [RW-1:0] ev_worst;

   always_comb begin
      ev_hit      = 1'b0;
      ev_free     = 1'b0;
      ev_found    = 1'b0;
      ev_hit_way  = '0;
      ev_free_way = '0;
      ev_lru_way  = '0;
      ev_worst    = '0;
      for (int w = 0; w < TABLE_WAYS; w++) begin
         if (meta_rd_ff.valid[w]) begin
            ev_found = (ent_rd_ff[w].cgroup == key_cg_ff)
                    && (ent_rd_ff[w].addresses == key_addr_ff)
                    && (ent_rd_ff[w].ports_protocol == key_pp_ff);
            if (ev_found && !ev_hit) begin
               ev_hit     = 1'b1;
               ev_hit_way = WW'(w);
            end
         end else begin
            ev_found = 1'b0;
            if (!ev_free) begin
               ev_free     = 1'b1;
               ev_free_way = WW'(w);
            end
         end
         if (meta_rd_ff.rank[w] >= ev_worst) begin
            ev_worst   = meta_rd_ff.rank[w];
            ev_lru_way = WW'(w);
         end
      end
   end

   logic          hit_ff, evict_ff;
   logic [WW-1:0] sel_ff;

   // ---------------------------------------------------------------- write back
   entry_type     wb_old, wb_new;
   logic [RW-1:0] wb_rank_old;

   always_comb begin
      wb_old = ent_rd_ff[sel_ff];
      wb_new = wb_old;
      if (hit_ff) begin
         if (egr_ff) begin
            wb_new.tx_bytes = wb_old.tx_bytes + len_ff;
            wb_new.tx_pkts  = wb_old.tx_pkts + 64'd1;
         end else begin
            wb_new.rx_bytes = wb_old.rx_bytes + len_ff;
            wb_new.rx_pkts  = wb_old.rx_pkts + 64'd1;
         end
      end else begin
         wb_new.cgroup         = key_cg_ff;
         wb_new.addresses      = key_addr_ff;
         wb_new.ports_protocol = key_pp_ff;
         wb_new.tx_bytes       = egr_ff ? len_ff : 64'd0;
         wb_new.tx_pkts        = egr_ff ? 64'd1 : 64'd0;
         wb_new.rx_bytes       = egr_ff ? 64'd0 : len_ff;
         wb_new.rx_pkts        = egr_ff ? 64'd0 : 64'd1;
      end
      ent_wd         = ent_rd_ff;
      ent_wd[sel_ff] = wb_new;

      // touch: ways more recent than the chosen one age by one
      wb_rank_old = meta_rd_ff.rank[sel_ff];
      meta_wd     = meta_rd_ff;
      for (int w = 0; w < TABLE_WAYS; w++) begin
         if (meta_rd_ff.rank[w] < wb_rank_old) meta_wd.rank[w] = meta_rd_ff.rank[w] + 1'b1;
      end
      meta_wd.rank[sel_ff]  = '0;
      meta_wd.valid[sel_ff] = 1'b1;
      if (state_ff == S_CLEAR) begin
         meta_wd.valid = '0;
         for (int w = 0; w < TABLE_WAYS; w++) meta_wd.rank[w] = RW'(w);
      end
      ent_we  = (state_ff == S_WRITE);
      meta_we = (state_ff == S_WRITE) || (state_ff == S_CLEAR);
      meta_wa = (state_ff == S_CLEAR) ? clr_ff : set_ff;
   end

   // ---------------------------------------------------------------- set index
   // hash mod set count in three steps: the top 32 bits, then the partial
   // remainder with each lower 16-bit chunk appended; each step estimates the
   // quotient by the reciprocal (at most one short), then subtracts
   logic [31:0] hash_ff, x_ff, q_ff;
   logic [1:0]  step_ff;
   logic [64:0] fold_prod;
   logic [16:0] fold_qd, fold_diff, fold_rem;
   logic [15:0] fold_chunk;

   always_comb begin
      fold_prod  = {33'd0, x_ff} * {32'd0, RECIP};
      fold_qd    = 17'(q_ff * 32'(DIV_C));
      // true remainder is below twice the set count, so 17 bits hold it
      fold_diff  = x_ff[16:0] - fold_qd;
      fold_rem   = (fold_diff >= DIV_C) ? fold_diff - DIV_C : fold_diff;
      fold_chunk = (step_ff == 2'd0) ? hash_ff[31:16] : hash_ff[15:0];
   end

   // ---------------------------------------------------------------- control
   logic [RSP_DATA_W-1:0] res_ff;
   logic          rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register loads from S_OUT when free or draining
         if ((state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SW'(SETS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  hash_ff  <= in_hash[31:0];
                  x_ff     <= in_hash[63:32];
                  step_ff  <= '0;
                  res_ff   <= '0;
                  state_ff <= in_drop ? S_OUT : S_HASH;
               end
            end
            S_HASH: begin
               q_ff     <= 32'(fold_prod >> (32 + RL));
               state_ff <= S_FOLD;
            end
            S_FOLD: begin
               if (step_ff == 2'd2) begin
                  set_ff   <= fold_rem[SW-1:0];
                  state_ff <= S_READ;
               end else begin
                  x_ff     <= 32'({fold_rem[SW-1:0], fold_chunk});
                  step_ff  <= step_ff + 2'd1;
                  state_ff <= S_HASH;
               end
            end
            S_READ: state_ff <= S_EVAL;
            S_EVAL: begin
               hit_ff   <= ev_hit;
               evict_ff <= !ev_hit && !ev_free;
               sel_ff   <= ev_hit ? ev_hit_way : (ev_free ? ev_free_way : ev_lru_way);
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               res_ff <= RSP_DATA_W'({wb_new.rx_pkts, wb_new.rx_bytes,
                                      wb_new.tx_pkts, wb_new.tx_bytes,
                                      evict_ff, !hit_ff, 1'b1});
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("request taken during clearing pass");
   a_evict_is_new: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[2] || rsp_tdata[1]))
      else $error("eviction without a new flow");
   a_new_is_recorded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> (rsp_tdata[258:1] == '0))
      else $error("dropped packet with nonzero result");
   a_write_then_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |=> (state_ff == S_OUT))
      else $error("write-back not followed by output load");
`endif

endmodule

// ===== test/flow_counter_table_core_tb.sv =====
// self-checking testbench for flow_counter_table_core: packet items in, flow counters out
// depends on fcnt_pkg and the flow_counter_table_core rtl
module flow_counter_table_core_tb;
   import fcnt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WAYS   = DEF_TABLE_WAYS;
   localparam int SETS   = DEF_TABLE_ENTRIES / DEF_TABLE_WAYS;
   localparam int NFLOWS = 24;

   typedef struct {
      logic [63:0] cgroup;
      bit          header_ok;
      logic [3:0]  version;
      logic [7:0]  proto;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      bit          ports_ok;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      bit          egress;
      logic [15:0] length;
   } packet_type;

   typedef struct {
      bit          recorded;
      bit          new_flow;
      bit          evicted;
      logic [63:0] tx_bytes;
      logic [63:0] tx_pkts;
      logic [63:0] rx_bytes;
      logic [63:0] rx_pkts;
   } tally_type;

   // flow keys as seen in the egress direction
   typedef struct {
      logic [63:0] cgroup;
      logic [31:0] saddr;
      logic [31:0] daddr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  proto;
      bit          ports_ok;
   } flow_type;

   class flow_ledger;
      tally_type   pending_q[$];
      int          errors;
      bit          valid_m[int];
      logic [63:0] cg_m[int], addr_m[int], pp_m[int];
      logic [63:0] btx_m[int], ptx_m[int], brx_m[int], prx_m[int];
      int          rank_m[int];

      function int rank_of(int slot);
         return rank_m.exists(slot) ? rank_m[slot] : slot % WAYS;
      endfunction

      function void promote(int base, int way);
         int old;
         old = rank_of(base + way);
         for (int w = 0; w < WAYS; w++)
            if (rank_of(base + w) < old) rank_m[base + w] = rank_of(base + w) + 1;
         rank_m[base + way] = 0;
      endfunction

      function void note_packet(packet_type p);
         tally_type   t;
         logic [15:0] sp, dp;
         logic [31:0] sa, da;
         logic [63:0] addrs, pp, h;
         int          base, slot, hit_way, fill, worst;
         bit          hit, free_found;
         t = '{default: 0};
         if (!p.header_ok || p.version != IP_V4) begin
            pending_q.push_back(t);
            return;
         end
         sp = 0;
         dp = 0;
         if ((p.proto == PROTO_TCP || p.proto == PROTO_UDP) && p.ports_ok) begin
            sp = p.src_port;
            dp = p.dst_port;
         end
         if (p.egress) begin
            sa = p.src_addr;
            da = p.dst_addr;
         end else begin
            // ingress: key is seen from the local end
            sa = p.dst_addr;
            da = p.src_addr;
            {sp, dp} = {dp, sp};
         end
         addrs = {sa, da};
         pp    = {24'd0, sp, dp, p.proto};
         h = p.cgroup ^ (p.cgroup >> 32) ^ {32'd0, sa} ^ {32'd0, da} ^ {32'd0, sp, dp}
             ^ {56'd0, p.proto};
         base = int'(h % 64'(SETS)) * WAYS;
         hit = 0;
         free_found = 0;
         hit_way = 0;
         fill = 0;
         for (int w = 0; w < WAYS; w++) begin
            slot = base + w;
            if (valid_m.exists(slot)) begin
               if (!hit && cg_m[slot] == p.cgroup && addr_m[slot] == addrs && pp_m[slot] == pp)
               begin
                  hit = 1;
                  hit_way = w;
               end
            end else if (!free_found) begin
               free_found = 1;
               fill = w;
            end
         end
         if (hit) begin
            slot = base + hit_way;
            if (p.egress) begin
               btx_m[slot] += 64'(p.length);
               ptx_m[slot] += 64'd1;
            end else begin
               brx_m[slot] += 64'(p.length);
               prx_m[slot] += 64'd1;
            end
            promote(base, hit_way);
         end else begin
            if (!free_found) begin
               // every way taken: replace the least recent one
               worst = 0;
               for (int w = 0; w < WAYS; w++)
                  if (rank_of(base + w) >= worst) begin
                     worst = rank_of(base + w);
                     fill = w;
                  end
               t.evicted = 1;
            end
            slot = base + fill;
            valid_m[slot] = 1;
            cg_m[slot]   = p.cgroup;
            addr_m[slot] = addrs;
            pp_m[slot]   = pp;
            btx_m[slot]  = p.egress ? 64'(p.length) : 64'd0;
            ptx_m[slot]  = p.egress ? 64'd1 : 64'd0;
            brx_m[slot]  = p.egress ? 64'd0 : 64'(p.length);
            prx_m[slot]  = p.egress ? 64'd0 : 64'd1;
            promote(base, fill);
            t.new_flow = 1;
         end
         t.recorded = 1;
         t.tx_bytes = btx_m[slot];
         t.tx_pkts  = ptx_m[slot];
         t.rx_bytes = brx_m[slot];
         t.rx_pkts  = prx_m[slot];
         pending_q.push_back(t);
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] d);
         tally_type   e;
         logic [63:0] want[7], got[7];
         string       names[7];
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result item %h", d));
            return;
         end
         e = pending_q.pop_front();
         names = '{"recorded", "new_flow", "evicted", "tx_bytes", "tx_pkts",
                   "rx_bytes", "rx_pkts"};
         want = '{64'(e.recorded), 64'(e.new_flow), 64'(e.evicted), e.tx_bytes,
                  e.tx_pkts, e.rx_bytes, e.rx_pkts};
         got  = '{64'(d[0]), 64'(d[1]), 64'(d[2]), d[66:3], d[130:67], d[194:131],
                  d[258:195]};
         for (int i = 0; i < 7; i++)
            if (got[i] !== want[i])
               report($sformatf("%s expected %h got %h", names[i], want[i], got[i]));
         if (d[RSP_DATA_W-1:259] !== '0) report("nonzero fill in result item");
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   flow_ledger ledger = new();
   flow_type   flows[NFLOWS];
   int         burst_left = 0;
   int         hold_left = 0;

   always #6 clock = ~clock;

   flow_counter_table_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic logic [REQ_DATA_W-1:0] pack_packet(packet_type p);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[63:0]    = p.cgroup;
      d[64]      = p.header_ok;
      d[68:65]   = p.version;
      d[76:69]   = p.proto;
      d[108:77]  = p.src_addr;
      d[140:109] = p.dst_addr;
      d[141]     = p.ports_ok;
      d[157:142] = p.src_port;
      d[173:158] = p.dst_port;
      d[189:174] = p.length;
      return d;
   endfunction

   function automatic packet_type random_packet();
      packet_type p;
      p.cgroup    = {$urandom, $urandom};
      p.header_ok = $urandom_range(1);
      p.version   = $urandom_range(15);
      p.proto     = $urandom_range(255);
      p.src_addr  = $urandom;
      p.dst_addr  = $urandom;
      p.ports_ok  = $urandom_range(1);
      p.src_port  = $urandom_range(65535);
      p.dst_port  = $urandom_range(65535);
      p.egress    = $urandom_range(1);
      p.length    = $urandom_range(65535);
      return p;
   endfunction

   // packet of a known flow; ingress packets carry the header swapped
   function automatic packet_type flow_packet(int f, bit egress, logic [15:0] len);
      packet_type p;
      p = random_packet();
      p.cgroup    = flows[f].cgroup;
      p.header_ok = 1;
      p.version   = IP_V4;
      p.proto     = flows[f].proto;
      p.ports_ok  = flows[f].ports_ok;
      p.egress    = egress;
      p.length    = len;
      if (egress) begin
         p.src_addr = flows[f].saddr;
         p.dst_addr = flows[f].daddr;
         p.src_port = flows[f].sport;
         p.dst_port = flows[f].dport;
      end else begin
         p.src_addr = flows[f].daddr;
         p.dst_addr = flows[f].saddr;
         p.src_port = flows[f].dport;
         p.dst_port = flows[f].sport;
      end
      return p;
   endfunction

   // groups of six flows that differ only in cgroup bits that cancel out of
   // the low set-index bits, so each group crowds one set
   task automatic build_flows();
      flow_type g;
      for (int i = 0; i < NFLOWS; i++) begin
         if (i % 6 == 0) begin
            g.cgroup   = {$urandom, $urandom};
            g.saddr    = $urandom;
            g.daddr    = $urandom;
            g.sport    = $urandom_range(65535);
            g.dport    = $urandom_range(65535);
            case ($urandom_range(3))
               0: g.proto = PROTO_TCP;
               1: g.proto = PROTO_UDP;
               default: g.proto = $urandom_range(255);
            endcase
            g.ports_ok = $urandom_range(3) != 0;
         end
         flows[i] = g;
         flows[i].cgroup = g.cgroup ^ (64'(i % 6 + 1) << 16) ^ (64'($urandom_range(255)) << 48);
      end
   endtask

   // offer one item; bursts of random length separated by random gaps
   task automatic send_packet(packet_type p);
      @(negedge clock);
      req_tvalid <= 1;
      req_tdata  <= pack_packet(p);
      req_tuser  <= p.egress;
      do @(posedge clock); while (!req_tready);
      ledger.note_packet(p);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_tvalid <= 0;
         repeat ($urandom_range(40)) @(negedge clock);
         burst_left = $urandom_range(12);
      end
   endtask

   // receiver: a randomly chosen stall pattern drives rsp_tready; a requested hold-off
   // keeps it low for a counted stretch
   initial begin
      int cyc;
      int mode;
      cyc = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (cyc % 64 == 0) mode = $urandom_range(3);
         cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(1);
               2: rsp_tready <= $urandom_range(3) == 0;
               default: rsp_tready <= (cyc % 8) < 5;
            endcase
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) ledger.check_result(rsp_tdata);

   initial begin
      #3ms;
      $display("flow_counter_table_core_tb: errors");
      $finish;
   end

   initial begin
      packet_type p;
      int         pick;
      build_flows();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // dropped: unreadable header, then wrong versions
      p = random_packet();
      p.header_ok = 0;
      p.version = IP_V4;
      p.cgroup = '1;
      send_packet(p);
      p = random_packet();
      p.header_ok = 1;
      p.version = 4'd0;
      send_packet(p);
      p.version = 4'd15;
      send_packet(p);
      // one tcp flow both ways, extreme lengths and cgroup
      p = random_packet();
      p.header_ok = 1;
      p.version = IP_V4;
      p.proto = PROTO_TCP;
      p.ports_ok = 1;
      p.cgroup = '1;
      p.egress = 1;
      p.length = 16'hffff;
      send_packet(p);
      {p.src_addr, p.dst_addr} = {p.dst_addr, p.src_addr};
      {p.src_port, p.dst_port} = {p.dst_port, p.src_port};
      p.egress = 0;
      p.length = 0;
      send_packet(p);
      p.length = 16'hffff;
      send_packet(p);
      // udp with unreadable ports: ports drop out of the key
      p = random_packet();
      p.header_ok = 1;
      p.version = IP_V4;
      p.proto = PROTO_UDP;
      p.ports_ok = 0;
      p.cgroup = '0;
      send_packet(p);
      p.src_port = ~p.src_port;
      p.dst_port = ~p.dst_port;
      send_packet(p);
      // protocol without ports, even when port words are readable
      p.proto = 8'hff;
      p.ports_ok = 1;
      p.src_addr = '1;
      p.dst_addr = '1;
      send_packet(p);
      p.src_port = ~p.src_port;
      send_packet(p);
      p = '{default: 0};
      p.header_ok = 1;
      p.version = IP_V4;
      send_packet(p);
      // six flows into one set: fill four ways, then lru replacements
      for (int i = 0; i < 6; i++) send_packet(flow_packet(i, 1, $urandom_range(65535)));
      send_packet(flow_packet(0, 0, 16'd1));
      send_packet(flow_packet(5, 0, 16'hffff));
      send_packet(flow_packet(3, 1, 16'd0));

      for (int n = 0; n < 400; n++) begin
         if (n == 150) hold_left = 400;
         pick = $urandom_range(99);
         if (pick < 80) begin
            send_packet(flow_packet($urandom_range(NFLOWS - 1), $urandom_range(1),
                                    $urandom_range(65535)));
         end else if (pick < 90) begin
            p = random_packet();
            if ($urandom_range(1)) p.header_ok = 0;
            else if (p.version == IP_V4) p.version = ~p.version;
            send_packet(p);
         end else begin
            send_packet(random_packet());
         end
      end

      @(negedge clock);
      req_tvalid <= 0;
      while (ledger.pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending_q.size() == 0)
         $display("flow_counter_table_core_tb: clean");
      else
         $display("flow_counter_table_core_tb: errors");
      $finish;
   end

endmodule
